>>> hdl/assert_macros.svh
// Assertion macros shared by the buffer cache directory modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define BBCD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define BBCD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/bbcd_pkg.sv
// Shared constants, codes and types of the buffer cache directory.
package bbcd_pkg;

   // Directory geometry
   localparam int NUM_ENTRIES = 32;
   localparam int IDX_W       = $clog2(NUM_ENTRIES);
   localparam int TREE_N      = 1 << IDX_W;

   // Field widths
   localparam int KIND_W   = 3;
   localparam int DEV_W    = 8;
   localparam int BLK_W    = 32;
   localparam int ENTRY_W  = 5;
   localparam int TIME_W   = 32;
   localparam int CNT_W    = 8;
   localparam int STATUS_W = 2;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // Operation codes
   localparam logic [KIND_W-1:0] KIND_READ    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PIN     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_UNPIN   = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

   // How the target entry was chosen
   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_OTHER   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HIT     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MISS    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NO_FREE = 2'd3;

   // Victim tree settle time: leaf register plus one register per level
   localparam int SCAN_CYCLES = IDX_W + 1;
   localparam int SCAN_W      = $clog2(SCAN_CYCLES + 1);

   typedef struct packed {
      logic load;
      logic look;
      logic sel_hit;
      logic sel_victim;
      logic apply;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_read;
      logic hit_found;
      logic out_free;
   } ctrl_sts_type;

   // Map a directory index onto the entry field
   function automatic logic [ENTRY_W-1:0] idx_to_entry(input logic [IDX_W-1:0] idx);
      logic [IDX_W+ENTRY_W-1:0] ext;
      ext = {{ENTRY_W{1'b0}}, idx};
      return ext[ENTRY_W-1:0];
   endfunction

   // Map the entry field onto a directory index
   function automatic logic [IDX_W-1:0] entry_to_idx(input logic [ENTRY_W-1:0] entry);
      logic [IDX_W+ENTRY_W-1:0] ext;
      ext = {{IDX_W{1'b0}}, entry};
      return ext[IDX_W-1:0];
   endfunction

   // True when the entry field names an existing entry
   function automatic logic entry_in_range(input logic [ENTRY_W-1:0] entry);
      logic [IDX_W+ENTRY_W-1:0] ext;
      ext = {{IDX_W{1'b0}}, entry};
      return ext < (IDX_W + ENTRY_W)'(NUM_ENTRIES);
   endfunction

endpackage

>>> hdl/bbcd_req_if.sv
// Request channel of the buffer cache directory.
interface bbcd_req_if;
   logic                            valid;
   logic                            ready;
   logic [bbcd_pkg::KIND_W-1:0]     kind;
   logic [bbcd_pkg::DEV_W-1:0]      device;
   logic [bbcd_pkg::BLK_W-1:0]      block_number;
   logic [bbcd_pkg::ENTRY_W-1:0]    entry_in;
   logic [bbcd_pkg::TIME_W-1:0]     now;

   modport source (output valid, kind, device, block_number, entry_in, now, input ready);
   modport sink   (input valid, kind, device, block_number, entry_in, now, output ready);
endinterface

>>> hdl/bbcd_rsp_if.sv
// Response channel of the buffer cache directory.
interface bbcd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bbcd_pkg::ENTRY_W-1:0]    entry_out;
   logic                            hit;
   logic                            need_disk_read;
   logic                            need_disk_write;
   logic [bbcd_pkg::STATUS_W-1:0]   status;

   modport source (output valid, entry_out, hit, need_disk_read, need_disk_write, status,
                   input ready);
   modport sink   (input valid, entry_out, hit, need_disk_read, need_disk_write, status,
                   output ready);
endinterface

>>> hdl/bbcd_lru_tree.sv
// Registered minimum tree that finds the oldest unreferenced entry.
module bbcd_lru_tree (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [bbcd_pkg::NUM_ENTRIES-1:0]  leaf_valid,
   input  logic [bbcd_pkg::TIME_W-1:0]       leaf_time [bbcd_pkg::NUM_ENTRIES],
   output logic                              root_valid,
   output logic [bbcd_pkg::IDX_W-1:0]        root_idx
);

   localparam int NODES = 2 * bbcd_pkg::TREE_N;

   logic                          node_valid_ff [1:NODES-1];
   logic [bbcd_pkg::TIME_W-1:0]   node_time_ff  [1:NODES-1];
   logic [bbcd_pkg::IDX_W-1:0]    node_idx_ff   [1:NODES-1];
   logic                          node_valid_in [1:NODES-1];
   logic [bbcd_pkg::TIME_W-1:0]   node_time_in  [1:NODES-1];
   logic [bbcd_pkg::IDX_W-1:0]    node_idx_in   [1:NODES-1];

   // Load leaves; pad slots past the last entry never win
   for (genvar g = 0; g < bbcd_pkg::TREE_N; g++) begin : g_leaf
      if (g < bbcd_pkg::NUM_ENTRIES) begin : g_real
         assign node_valid_in[bbcd_pkg::TREE_N + g] = leaf_valid[g];
         assign node_time_in[bbcd_pkg::TREE_N + g]  = leaf_time[g];
      end else begin : g_pad
         assign node_valid_in[bbcd_pkg::TREE_N + g] = 1'b0;
         assign node_time_in[bbcd_pkg::TREE_N + g]  = '0;
      end
      assign node_idx_in[bbcd_pkg::TREE_N + g] = bbcd_pkg::IDX_W'(g);
   end

   // Pick the older child; the left child holds lower indices and wins ties
   for (genvar k = 1; k < bbcd_pkg::TREE_N; k++) begin : g_node
      logic take_left;
      assign take_left = node_valid_ff[2*k] &&
                         (!node_valid_ff[2*k+1] || node_time_ff[2*k] <= node_time_ff[2*k+1]);
      assign node_valid_in[k] = node_valid_ff[2*k] | node_valid_ff[2*k+1];
      assign node_time_in[k]  = take_left ? node_time_ff[2*k] : node_time_ff[2*k+1];
      assign node_idx_in[k]   = take_left ? node_idx_ff[2*k]  : node_idx_ff[2*k+1];
   end

   // Advance every level each cycle
   always_ff @(posedge clock) begin
      for (int n = 1; n < NODES; n++) begin
         node_time_ff[n] <= node_time_in[n];
         node_idx_ff[n]  <= node_idx_in[n];
         if (reset) begin
            node_valid_ff[n] <= 1'b0;
         end else begin
            node_valid_ff[n] <= node_valid_in[n];
         end
      end
   end

   assign root_valid = node_valid_ff[1];
   assign root_idx   = node_idx_ff[1];

endmodule

>>> hdl/bbcd_ctrl.sv
// Controller that sequences lookup, victim search and update of the directory.
`include "assert_macros.svh"

module bbcd_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  bbcd_pkg::ctrl_sts_type      sts,
   output bbcd_pkg::ctrl_cmd_type      cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOOK   = 3'd1;
   localparam logic [2:0] S_ENCODE = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_APPLY  = 3'd4;

   logic [2:0]                     state_ff, state_in;
   logic [bbcd_pkg::SCAN_W-1:0]    scan_cnt_ff, scan_cnt_in;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      scan_cnt_in = scan_cnt_ff;
      cmd         = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.look = 1'b1;
            state_in = sts.is_read ? S_ENCODE : S_APPLY;
         end
         S_ENCODE: begin
            if (sts.hit_found) begin
               cmd.sel_hit = 1'b1;
               state_in    = S_APPLY;
            end else begin
               scan_cnt_in = '0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            scan_cnt_in = scan_cnt_ff + bbcd_pkg::SCAN_W'(1);
            if (scan_cnt_ff == bbcd_pkg::SCAN_W'(bbcd_pkg::SCAN_CYCLES - 1)) begin
               cmd.sel_victim = 1'b1;
               state_in       = S_APPLY;
            end
         end
         S_APPLY: begin
            if (sts.out_free) begin
               cmd.apply = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and scan count
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         scan_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         scan_cnt_ff <= scan_cnt_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   `BBCD_ASSERT_IMP(a_one_cmd, clock, reset, 1'b1, $onehot0(cmd), "more than one command")
   `BBCD_ASSERT_IMP(a_apply_free, clock, reset, cmd.apply, sts.out_free, "update with full output")
   `BBCD_ASSERT_IMP(a_victim_miss, clock, reset, cmd.sel_victim, !sts.hit_found, "victim on hit")

endmodule

>>> hdl/bbcd_dpath.sv
// Datapath: request register, tag match, entry state, update and result register.
`include "assert_macros.svh"

module bbcd_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [bbcd_pkg::KIND_W-1:0]       req_kind,
   input  logic [bbcd_pkg::DEV_W-1:0]        req_device,
   input  logic [bbcd_pkg::BLK_W-1:0]        req_block_number,
   input  logic [bbcd_pkg::ENTRY_W-1:0]      req_entry_in,
   input  logic [bbcd_pkg::TIME_W-1:0]       req_now,
   input  bbcd_pkg::ctrl_cmd_type            cmd,
   output bbcd_pkg::ctrl_sts_type            sts,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bbcd_pkg::ENTRY_W-1:0]      rsp_entry_out,
   output logic                              rsp_hit,
   output logic                              rsp_need_disk_read,
   output logic                              rsp_need_disk_write,
   output logic [bbcd_pkg::STATUS_W-1:0]     rsp_status
);

   localparam int N = bbcd_pkg::NUM_ENTRIES;

   // Latched request word
   logic [bbcd_pkg::KIND_W-1:0]    kind_ff;
   logic [bbcd_pkg::DEV_W-1:0]     dev_ff;
   logic [bbcd_pkg::BLK_W-1:0]     blk_ff;
   logic [bbcd_pkg::ENTRY_W-1:0]   entry_ff;
   logic [bbcd_pkg::TIME_W-1:0]    now_ff;

   // Entry state
   logic [bbcd_pkg::DEV_W-1:0]     tag_dev_ff [N];
   logic [bbcd_pkg::BLK_W-1:0]     tag_blk_ff [N];
   logic [bbcd_pkg::CNT_W-1:0]     cnt_ff     [N];
   logic                           cv_ff      [N];
   logic [bbcd_pkg::TIME_W-1:0]    time_ff    [N];

   // Lookup and target selection
   logic [N-1:0]                   match_in, match_ff;
   logic [bbcd_pkg::IDX_W-1:0]     hit_idx;
   logic [bbcd_pkg::IDX_W-1:0]     target_ff;
   logic [bbcd_pkg::MODE_W-1:0]    mode_ff;
   logic [N-1:0]                   free_vec;
   logic                           victim_valid;
   logic [bbcd_pkg::IDX_W-1:0]     victim_idx;

   // Update and result
   logic [bbcd_pkg::CNT_W-1:0]     cur_cnt, cnt_new;
   logic                           cur_cv;
   logic                           we_tag, we_cnt, we_cv, we_time;
   logic [bbcd_pkg::ENTRY_W-1:0]   res_entry;
   logic                           res_hit, res_rd, res_wr;
   logic [bbcd_pkg::STATUS_W-1:0]  res_status;

   logic                           rsp_valid_ff;
   logic [bbcd_pkg::ENTRY_W-1:0]   rsp_entry_ff;
   logic                           rsp_hit_ff, rsp_rd_ff, rsp_wr_ff;
   logic [bbcd_pkg::STATUS_W-1:0]  rsp_status_ff;

   // Compare every tag against the request; mark unreferenced entries
   always_comb begin
      for (int i = 0; i < N; i++) begin
         match_in[i] = (tag_dev_ff[i] == dev_ff) && (tag_blk_ff[i] == blk_ff);
         free_vec[i] = (cnt_ff[i] == '0);
      end
   end

   // Lowest matching index
   always_comb begin
      hit_idx = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_idx = bbcd_pkg::IDX_W'(i);
         end
      end
   end

   bbcd_lru_tree u_lru_tree (
      .clock      (clock),
      .reset      (reset),
      .leaf_valid (free_vec),
      .leaf_time  (time_ff),
      .root_valid (victim_valid),
      .root_idx   (victim_idx)
   );

   // Latch the request, the match vector and the chosen entry
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_kind;
         dev_ff    <= req_device;
         blk_ff    <= req_block_number;
         entry_ff  <= req_entry_in;
         now_ff    <= req_now;
         target_ff <= bbcd_pkg::entry_to_idx(req_entry_in);
         mode_ff   <= bbcd_pkg::MODE_OTHER;
      end
      if (cmd.look) begin
         match_ff <= match_in;
      end
      if (cmd.sel_hit) begin
         target_ff <= hit_idx;
         mode_ff   <= bbcd_pkg::MODE_HIT;
      end
      if (cmd.sel_victim) begin
         target_ff <= victim_idx;
         mode_ff   <= victim_valid ? bbcd_pkg::MODE_MISS : bbcd_pkg::MODE_NO_FREE;
      end
   end

   assign cur_cnt = cnt_ff[target_ff];
   assign cur_cv  = cv_ff[target_ff];

   // Work out the entry update and the result word
   always_comb begin
      we_tag     = 1'b0;
      we_cnt     = 1'b0;
      we_cv      = 1'b0;
      we_time    = 1'b0;
      cnt_new    = cur_cnt;
      res_entry  = bbcd_pkg::idx_to_entry(target_ff);
      res_hit    = 1'b0;
      res_rd     = 1'b0;
      res_wr     = 1'b0;
      res_status = bbcd_pkg::ST_OK;
      unique case (mode_ff)
         bbcd_pkg::MODE_NO_FREE: begin
            res_entry  = '0;
            res_status = bbcd_pkg::ST_NO_FREE;
         end
         bbcd_pkg::MODE_HIT: begin
            res_hit = 1'b1;
            if (cur_cnt == bbcd_pkg::CNT_MAX) begin
               res_status = bbcd_pkg::ST_OVERFLOW;
            end else begin
               we_cnt  = 1'b1;
               cnt_new = cur_cnt + bbcd_pkg::CNT_W'(1);
               if (!cur_cv) begin
                  we_cv   = 1'b1;
                  we_time = 1'b1;
                  res_rd  = 1'b1;
               end
            end
         end
         bbcd_pkg::MODE_MISS: begin
            we_tag  = 1'b1;
            we_cnt  = 1'b1;
            cnt_new = bbcd_pkg::CNT_W'(1);
            we_cv   = 1'b1;
            we_time = 1'b1;
            res_rd  = 1'b1;
         end
         bbcd_pkg::MODE_OTHER: begin
            priority if (kind_ff > bbcd_pkg::KIND_UNPIN) begin
               res_entry = '0;
            end else if (!bbcd_pkg::entry_in_range(entry_ff)) begin
               res_entry = entry_ff;
            end else if (kind_ff == bbcd_pkg::KIND_WRITE) begin
               we_time = 1'b1;
               res_wr  = 1'b1;
            end else if (kind_ff == bbcd_pkg::KIND_PIN) begin
               if (cur_cnt == bbcd_pkg::CNT_MAX) begin
                  res_status = bbcd_pkg::ST_OVERFLOW;
               end else begin
                  we_cnt  = 1'b1;
                  cnt_new = cur_cnt + bbcd_pkg::CNT_W'(1);
               end
            end else begin
               // release and unpin drop one reference
               if (cur_cnt == '0) begin
                  res_status = bbcd_pkg::ST_UNDERFLOW;
               end else begin
                  we_cnt  = 1'b1;
                  cnt_new = cur_cnt - bbcd_pkg::CNT_W'(1);
               end
            end
         end
      endcase
   end

   // Write the target entry
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            tag_dev_ff[i] <= '0;
            tag_blk_ff[i] <= '0;
            cnt_ff[i]     <= '0;
            cv_ff[i]      <= 1'b0;
            time_ff[i]    <= '0;
         end
      end else if (cmd.apply) begin
         if (we_tag) begin
            tag_dev_ff[target_ff] <= dev_ff;
            tag_blk_ff[target_ff] <= blk_ff;
         end
         if (we_cnt) begin
            cnt_ff[target_ff] <= cnt_new;
         end
         if (we_cv) begin
            cv_ff[target_ff] <= 1'b1;
         end
         if (we_time) begin
            time_ff[target_ff] <= now_ff;
         end
      end
   end

   // Hold the result word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.apply) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         rsp_entry_ff  <= res_entry;
         rsp_hit_ff    <= res_hit;
         rsp_rd_ff     <= res_rd;
         rsp_wr_ff     <= res_wr;
         rsp_status_ff <= res_status;
      end
   end

   assign sts.is_read   = (kind_ff == bbcd_pkg::KIND_READ);
   assign sts.hit_found = |match_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_entry_out       = rsp_entry_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_need_disk_read  = rsp_rd_ff;
   assign rsp_need_disk_write = rsp_wr_ff;
   assign rsp_status          = rsp_status_ff;

   `BBCD_ASSERT_NXT(a_apply_rsp, clock, reset, cmd.apply, rsp_valid_ff, "no result after update")
   `BBCD_ASSERT_IMP(a_victim_free, clock, reset, cmd.apply && mode_ff == bbcd_pkg::MODE_MISS, cur_cnt == '0, "victim in use")
   `BBCD_ASSERT_IMP(a_nofree_quiet, clock, reset, rsp_valid_ff && rsp_status_ff == bbcd_pkg::ST_NO_FREE, rsp_entry_ff == '0 && !rsp_rd_ff && !rsp_hit_ff, "no free result not clean")

endmodule

>>> hdl/block_buffer_cache_directory.sv
// Top level of the buffer cache directory: controller, datapath and channels.
//
//   channel   dir   handshake      word
//   req_port  in    valid/ready    kind, device, block_number, entry_in, now
//   rsp_port  out   valid/ready    entry_out, hit, need_disk_read, need_disk_write, status
//
// One request at a time. Write, release, pin, unpin and unknown kinds go from lookup
// straight to update, a read hit also passes the encode step, and a read miss also the
// victim scan, whose length is set by the depth of the registered oldest-entry tree.
// The result register frees the request side: a new request is taken while a
// response still waits; only the update step waits on a stalled response.
// Synchronous reset clears all entries to device 0, block 0, count 0, invalid.
module block_buffer_cache_directory (
   input  logic            clock,
   input  logic            reset,
   bbcd_req_if.sink        req_port,
   bbcd_rsp_if.source      rsp_port
);

   bbcd_pkg::ctrl_cmd_type   cmd;
   bbcd_pkg::ctrl_sts_type   sts;

   bbcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bbcd_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .req_kind            (req_port.kind),
      .req_device          (req_port.device),
      .req_block_number    (req_port.block_number),
      .req_entry_in        (req_port.entry_in),
      .req_now             (req_port.now),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_valid           (rsp_port.valid),
      .rsp_ready           (rsp_port.ready),
      .rsp_entry_out       (rsp_port.entry_out),
      .rsp_hit             (rsp_port.hit),
      .rsp_need_disk_read  (rsp_port.need_disk_read),
      .rsp_need_disk_write (rsp_port.need_disk_write),
      .rsp_status          (rsp_port.status)
   );

endmodule
